FILE: rtl/core/tsme_pkg.sv
// Package for the two-set membership engine.
// Holds opcode and state encodings; no dependencies.
package tsme_pkg;

	typedef enum logic [3:0] {
		OP_INSERT    = 4'd0,
		OP_ERASE     = 4'd1,
		OP_CONTAINS  = 4'd2,
		OP_CLEAR     = 4'd3,
		OP_UNION     = 4'd4,
		OP_INTERSECT = 4'd5,
		OP_DIFF      = 4'd6,
		OP_SYMDIFF   = 4'd7,
		OP_RELATIONS = 4'd8
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OUTER,
		ST_INNER,
		ST_EMIT,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/two_set_membership_engine.sv
// Two-set membership engine: top level with the element memories and the sequencer.
// Depends on tsme_pkg.
//
// Usage: items enter on in_valid/in_stall with opcode, set_select and element.
// Results leave on out_valid/out_stall; every item gives at least one result,
// the final one marked by last. Set-algebra operations stream a run of
// elements (an empty run gives one result with has_element low). Each run
// element is held back until the next one is found, so the final one carries last.
// Each set lives in a memory of SET_CAPACITY entries with registered reads;
// every entry visited is first requested and then compared once its data lands.
// Insert, erase and contains walk the subject set; clear and unused opcodes
// walk nothing; intersection and difference search the other set for each
// subject entry; union, symmetric difference and relations then also search
// the subject set for each entry of the other.
// A result waits in the output register while the receiver stalls; the walk
// pauses until it is taken, so nothing is lost.
// Reset clears both counts and the sequencer; memory contents are not
// cleared since entries at or above the count are never read.
// One item is worked at a time; in_stall is high while an item is in work.
module two_set_membership_engine #(
	parameter int SET_CAPACITY = 16,
	parameter int ELEMENT_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         opcode,
	input  logic               set_select,
	input  logic signed [31:0] element,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_element,
	output logic               has_element,
	output logic               last,
	output logic               found,
	output logic [4:0]         count,
	output logic               overflow,
	output logic               is_subset,
	output logic               is_proper_subset,
	output logic               is_disjoint,
	output logic               is_equal
);

	localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
	localparam int CW = $clog2(SET_CAPACITY + 1);
	localparam int EW = (ELEMENT_BITS < 32) ? ELEMENT_BITS : 32;
	localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

	// element memories
	logic [EW-1:0] mem_a [SET_CAPACITY];
	logic [EW-1:0] mem_b [SET_CAPACITY];
	logic [EW-1:0] rd_a_q, rd_b_q;
	logic [AW-1:0] ra_a, ra_b, wa;
	logic          we_a, we_b;
	logic [EW-1:0] wd;

	logic [CW-1:0] cnt_a_q, cnt_b_q;

	// item registers
	tsme_pkg::state_t state_q, state_d;
	logic [3:0]  op_q;
	logic        sel_q;
	logic [EW-1:0] val_q;
	// walk registers: i over primary set, j over secondary, phase 1 = second pass
	logic [CW-1:0] i_q, j_q;
	logic          phase_q;
	logic          rd_pend_q;   // read data for the address of last cycle lands now
	logic          hit_q;       // inner hit / found
	logic [EW-1:0] cur_q;       // outer element under test
	logic [EW-1:0] pe_q;        // run element held until the next one or the end
	logic          pv_q;
	logic          sub_q, dis_q, sup_q;

	// output register
	logic        ov_q;
	logic [31:0] oe_q;
	logic        oh_q, ol_q, of_q, oo_q, os_q, op_sub_q, od_q, oq_q;
	logic [4:0]  oc_q;

	logic [CW-1:0] n_s, m_s;
	assign n_s = sel_q ? cnt_b_q : cnt_a_q;
	assign m_s = sel_q ? cnt_a_q : cnt_b_q;

	logic out_free;
	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != tsme_pkg::ST_IDLE);

	// read port data: primary (walked by i) is subject in phase 0, other in phase 1
	logic [EW-1:0] subj_rd, oth_rd;
	assign subj_rd = sel_q ? rd_b_q : rd_a_q;
	assign oth_rd  = sel_q ? rd_a_q : rd_b_q;

	logic is_alg, is_mem, is_rel;
	assign is_alg = (op_q == tsme_pkg::OP_UNION) || (op_q == tsme_pkg::OP_INTERSECT) ||
		(op_q == tsme_pkg::OP_DIFF) || (op_q == tsme_pkg::OP_SYMDIFF);
	assign is_mem = (op_q == tsme_pkg::OP_INSERT) || (op_q == tsme_pkg::OP_ERASE) ||
		(op_q == tsme_pkg::OP_CONTAINS);
	assign is_rel = (op_q == tsme_pkg::OP_RELATIONS);

	// lengths of primary/secondary walk for current phase
	logic [CW-1:0] plen, slen;
	assign plen = phase_q ? m_s : n_s;
	assign slen = phase_q ? n_s : m_s;
	logic [EW-1:0] prim_rd, sec_rd;
	assign prim_rd = phase_q ? oth_rd : subj_rd;
	assign sec_rd  = phase_q ? subj_rd : oth_rd;

	logic need_second;
	assign need_second = (op_q == tsme_pkg::OP_UNION) || (op_q == tsme_pkg::OP_SYMDIFF) ||
		is_rel;

	logic take_el;
	always_comb begin
		if (phase_q) take_el = !hit_q;
		else begin
			case (op_q)
				tsme_pkg::OP_UNION:     take_el = 1'b1;
				tsme_pkg::OP_INTERSECT: take_el = hit_q;
				default:                take_el = !hit_q;
			endcase
		end
	end

	// sequencer outputs: advance, result loads and memory writes
	logic emit_adv, emit_mid, done_go, erase_wr, ins_wr, load_out;
	always_comb begin
		emit_adv = 1'b0;
		emit_mid = 1'b0;
		done_go  = 1'b0;
		erase_wr = 1'b0;
		ins_wr   = 1'b0;
		unique case (state_q)
			tsme_pkg::ST_OUTER: begin
				erase_wr = (op_q == tsme_pkg::OP_ERASE) && hit_q && rd_pend_q;
			end
			tsme_pkg::ST_EMIT: begin
				emit_mid = is_alg && take_el && pv_q && out_free;
				emit_adv = !(is_alg && take_el && pv_q) || out_free;
			end
			tsme_pkg::ST_DONE: begin
				done_go = out_free;
				ins_wr  = out_free && (op_q == tsme_pkg::OP_INSERT) && !hit_q && (n_s < CAP);
			end
			default: ;
		endcase
	end
	assign load_out = emit_mid || done_go;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsme_pkg::ST_IDLE: if (in_valid) state_d = tsme_pkg::ST_OUTER;
			tsme_pkg::ST_OUTER: begin
				if (is_mem) begin
					if (rd_pend_q) begin
						if (op_q != tsme_pkg::OP_ERASE && subj_rd == val_q)
							state_d = tsme_pkg::ST_DONE;
					end else if (i_q >= n_s) state_d = tsme_pkg::ST_DONE;
				end else if (is_alg || is_rel) begin
					if (rd_pend_q) state_d = tsme_pkg::ST_INNER;
					else if (i_q >= plen && (phase_q || !need_second))
						state_d = tsme_pkg::ST_DONE;
				end else begin
					state_d = tsme_pkg::ST_DONE;
				end
			end
			tsme_pkg::ST_INNER: begin
				if (!rd_pend_q && (hit_q || j_q >= slen)) state_d = tsme_pkg::ST_EMIT;
			end
			tsme_pkg::ST_EMIT: if (emit_adv) state_d = tsme_pkg::ST_OUTER;
			tsme_pkg::ST_DONE: if (out_free) state_d = tsme_pkg::ST_IDLE;
			default: state_d = tsme_pkg::ST_IDLE;
		endcase
	end

	// memory addressing
	always_comb begin
		ra_a = i_q[AW-1:0];
		ra_b = i_q[AW-1:0];
		if (state_q == tsme_pkg::ST_INNER) begin
			// secondary walk: secondary set is other in phase 0
			if (sel_q ^ phase_q) ra_a = j_q[AW-1:0];
			else ra_b = j_q[AW-1:0];
		end
	end

	// erase shift writes entry i-1 with the data of i; insert appends at the count
	always_comb begin
		wa   = erase_wr ? AW'(i_q - CW'(1)) : n_s[AW-1:0];
		wd   = erase_wr ? subj_rd : val_q;
		we_a = (erase_wr || ins_wr) && !sel_q;
		we_b = (erase_wr || ins_wr) && sel_q;
	end

	// memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (we_a) mem_a[wa] <= wd;
		if (we_b) mem_b[wa] <= wd;
		rd_a_q <= mem_a[ra_a];
		rd_b_q <= mem_b[ra_b];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tsme_pkg::ST_IDLE;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			ov_q      <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			phase_q   <= 1'b0;
			rd_pend_q <= 1'b0;
			hit_q     <= 1'b0;
			pv_q      <= 1'b0;
			sub_q     <= 1'b1;
			dis_q     <= 1'b1;
			sup_q     <= 1'b1;
		end else begin
			state_q <= state_d;
			if (load_out) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				tsme_pkg::ST_IDLE: begin
					i_q <= '0; j_q <= '0; phase_q <= 1'b0;
					rd_pend_q <= 1'b0; hit_q <= 1'b0; pv_q <= 1'b0;
					sub_q <= 1'b1; dis_q <= 1'b1; sup_q <= 1'b1;
				end
				tsme_pkg::ST_OUTER: begin
					if (is_mem) begin
						// search, then for erase shift the later entries down
						if (rd_pend_q) begin
							rd_pend_q <= 1'b0;
							i_q <= i_q + CW'(1);
							if (!hit_q && subj_rd == val_q) hit_q <= 1'b1;
						end else if (i_q < n_s) begin
							rd_pend_q <= 1'b1;
						end
					end else if (is_alg || is_rel) begin
						if (rd_pend_q) begin
							// entry i landed: start the inner walk
							rd_pend_q <= 1'b0;
							j_q <= '0;
							hit_q <= 1'b0;
						end else if (i_q < plen) begin
							rd_pend_q <= 1'b1;
						end else if (!phase_q && need_second) begin
							phase_q <= 1'b1;
							i_q <= '0;
						end
					end
				end
				tsme_pkg::ST_INNER: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						j_q <= j_q + CW'(1);
						if (sec_rd == cur_q) hit_q <= 1'b1;
					end else if (!hit_q && j_q < slen) begin
						rd_pend_q <= 1'b1;
					end
				end
				tsme_pkg::ST_EMIT: begin
					if (is_rel) begin
						if (phase_q) begin
							if (!hit_q) sup_q <= 1'b0;
						end else if (hit_q) dis_q <= 1'b0;
						else sub_q <= 1'b0;
					end
					if (emit_adv) begin
						i_q <= i_q + CW'(1);
						if (is_alg && take_el) pv_q <= 1'b1;
					end
				end
				tsme_pkg::ST_DONE: begin
					if (out_free) begin
						if (op_q == tsme_pkg::OP_CLEAR) begin
							if (sel_q) cnt_b_q <= '0;
							else cnt_a_q <= '0;
						end
						if (ins_wr) begin
							if (sel_q) cnt_b_q <= cnt_b_q + CW'(1);
							else cnt_a_q <= cnt_a_q + CW'(1);
						end
						if (op_q == tsme_pkg::OP_ERASE && hit_q) begin
							if (sel_q) cnt_b_q <= cnt_b_q - CW'(1);
							else cnt_a_q <= cnt_a_q - CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// item capture, walk data and output payload
	always_ff @(posedge clk) begin
		if (state_q == tsme_pkg::ST_IDLE && in_valid) begin
			op_q  <= opcode;
			sel_q <= set_select;
			val_q <= element[EW-1:0];
		end
		if (state_q == tsme_pkg::ST_OUTER && !is_mem && rd_pend_q) cur_q <= prim_rd;
		if (state_q == tsme_pkg::ST_EMIT && emit_adv && is_alg && take_el) pe_q <= cur_q;
		// send the held run element; the new one takes its place
		if (emit_mid) begin
			oe_q <= 32'(pe_q); oh_q <= 1'b1; ol_q <= 1'b0; of_q <= 1'b0;
			oc_q <= 5'(n_s); oo_q <= 1'b0;
			os_q <= 1'b0; op_sub_q <= 1'b0; od_q <= 1'b0; oq_q <= 1'b0;
		end
		// final result of the item
		if (done_go) begin
			oe_q <= pv_q ? 32'(pe_q) : 32'd0;
			oh_q <= pv_q;
			ol_q <= 1'b1;
			of_q <= is_mem && hit_q;
			oo_q <= (op_q == tsme_pkg::OP_INSERT) && !hit_q && (n_s >= CAP);
			os_q <= 1'b0; op_sub_q <= 1'b0; od_q <= 1'b0; oq_q <= 1'b0;
			if (op_q == tsme_pkg::OP_CLEAR) oc_q <= '0;
			else if (ins_wr) oc_q <= 5'(n_s + CW'(1));
			else if (op_q == tsme_pkg::OP_ERASE && hit_q) oc_q <= 5'(n_s - CW'(1));
			else oc_q <= 5'(n_s);
			if (is_rel) begin
				os_q <= sub_q;
				op_sub_q <= sub_q && (n_s < m_s);
				od_q <= dis_q;
				oq_q <= sub_q && sup_q;
			end
		end
	end

	assign out_valid        = ov_q;
	assign out_element      = oe_q;
	assign has_element      = oh_q;
	assign last             = ol_q;
	assign found            = of_q;
	assign count            = oc_q;
	assign overflow         = oo_q;
	assign is_subset        = os_q;
	assign is_proper_subset = op_sub_q;
	assign is_disjoint      = od_q;
	assign is_equal         = oq_q;

	// counts never exceed capacity
	assert property (@(posedge clk) disable iff (!arst_n) cnt_a_q <= CAP && cnt_b_q <= CAP)
		else $error("set count above capacity");
	// no new item accepted while one is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tsme_pkg::ST_IDLE |-> in_stall)
		else $error("input open during work");
	// a memory write only happens on insert or erase
	assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> (op_q == tsme_pkg::OP_INSERT || op_q == tsme_pkg::OP_ERASE))
		else $error("stray memory write");
	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> (ov_q && $stable(oe_q) && $stable(ol_q)))
		else $error("stalled result changed");

endmodule

FILE: bench/tsme_checker.sv
// Checker for the two-set membership engine: watches both channels,
// predicts results from its own copy of the two sets, compares field by field.
// Depends on tsme_pkg.
`timescale 1ns / 1ps

module tsme_checker #(
	parameter int CAP = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [3:0]         opcode,
	input  logic               set_select,
	input  logic signed [31:0] element,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_element,
	input  logic               has_element,
	input  logic               last,
	input  logic               found,
	input  logic [4:0]         count,
	input  logic               overflow,
	input  logic               is_subset,
	input  logic               is_proper_subset,
	input  logic               is_disjoint,
	input  logic               is_equal,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [31:0] elem;
		logic        has;
		logic        lst;
		logic        fnd;
		logic [4:0]  cnt;
		logic        ovf;
		logic        sub;
		logic        psub;
		logic        dis;
		logic        eq;
	} set_result_t;

	logic [31:0] members [2][CAP];
	int          sizes [2];
	set_result_t expected_results [$];

	function automatic bit in_set(int s, logic [31:0] v);
		for (int i = 0; i < sizes[s]; i++)
			if (members[s][i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic push_result(logic [31:0] e, logic h, logic f, int c, logic o,
			logic sb, logic ps, logic ds, logic eq);
		set_result_t r;
		r = '{elem: e, has: h, lst: 1'b1, fnd: f, cnt: c[4:0], ovf: o,
			sub: sb, psub: ps, dis: ds, eq: eq};
		expected_results.push_back(r);
	endtask

	// Apply one item to the set copies and queue its results
	task automatic apply_item(logic [3:0] op, logic sel, logic [31:0] v);
		int s;
		int t;
		int n;
		int m;
		int k;
		bit f;
		bit sb;
		bit ds;
		bit sp;
		s = sel;
		t = !sel;
		n = sizes[s];
		m = sizes[t];
		k = 0;
		case (op) inside
			tsme_pkg::OP_INSERT: begin
				f = in_set(s, v);
				if (!f && n < CAP) begin
					members[s][n] = v;
					sizes[s] = n + 1;
				end
				push_result('0, 1'b0, f, sizes[s], !f && n == CAP,
					1'b0, 1'b0, 1'b0, 1'b0);
			end
			tsme_pkg::OP_ERASE: begin
				f = 1'b0;
				for (int i = 0; i < n; i++) begin
					if (!f && members[s][i] == v)
						f = 1'b1;
					if (f && i + 1 < n)
						members[s][i] = members[s][i + 1];
				end
				if (f)
					sizes[s] = n - 1;
				push_result('0, 1'b0, f, sizes[s], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			end
			tsme_pkg::OP_CONTAINS:
				push_result('0, 1'b0, in_set(s, v), n, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			tsme_pkg::OP_CLEAR: begin
				sizes[s] = 0;
				push_result('0, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			end
			tsme_pkg::OP_UNION, tsme_pkg::OP_INTERSECT, tsme_pkg::OP_DIFF,
			tsme_pkg::OP_SYMDIFF: begin
				for (int i = 0; i < n; i++) begin
					f = in_set(t, members[s][i]);
					if (op == tsme_pkg::OP_UNION || (op == tsme_pkg::OP_INTERSECT && f)
							|| ((op == tsme_pkg::OP_DIFF || op == tsme_pkg::OP_SYMDIFF)
							&& !f)) begin
						if (k > 0)
							expected_results[$].lst = 1'b0;
						push_result(members[s][i], 1'b1, 1'b0, n, 1'b0,
							1'b0, 1'b0, 1'b0, 1'b0);
						k++;
					end
				end
				if (op == tsme_pkg::OP_UNION || op == tsme_pkg::OP_SYMDIFF)
					for (int i = 0; i < m; i++)
						if (!in_set(s, members[t][i])) begin
							if (k > 0)
								expected_results[$].lst = 1'b0;
							push_result(members[t][i], 1'b1, 1'b0, n, 1'b0,
								1'b0, 1'b0, 1'b0, 1'b0);
							k++;
						end
				if (k == 0)
					push_result('0, 1'b0, 1'b0, n, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			end
			tsme_pkg::OP_RELATIONS: begin
				sb = 1'b1;
				ds = 1'b1;
				sp = 1'b1;
				for (int i = 0; i < n; i++)
					if (in_set(t, members[s][i]))
						ds = 1'b0;
					else
						sb = 1'b0;
				for (int i = 0; i < m; i++)
					if (!in_set(s, members[t][i]))
						sp = 1'b0;
				push_result('0, 1'b0, 1'b0, n, 1'b0, sb, sb && n < m, ds, sb && sp);
			end
			default: push_result('0, 1'b0, 1'b0, n, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Predict on input items, compare on output items
	always @(posedge clk or negedge arst_n) begin
		set_result_t w;
		if (!arst_n) begin
			sizes[0] = 0;
			sizes[1] = 0;
			errors = 0;
			expected_results.delete();
		end else begin
			if (in_valid && !in_stall)
				apply_item(opcode, set_select, element);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("unexpected item", out_element, '0);
				end else begin
					w = expected_results.pop_front();
					if (out_element !== w.elem) report("out_element", out_element, w.elem);
					if (has_element !== w.has)
						report("has_element", 32'(has_element), 32'(w.has));
					if (last !== w.lst) report("last", 32'(last), 32'(w.lst));
					if (found !== w.fnd) report("found", 32'(found), 32'(w.fnd));
					if (count !== w.cnt) report("count", 32'(count), 32'(w.cnt));
					if (overflow !== w.ovf)
						report("overflow", 32'(overflow), 32'(w.ovf));
					if (is_subset !== w.sub)
						report("is_subset", 32'(is_subset), 32'(w.sub));
					if (is_proper_subset !== w.psub)
						report("is_proper_subset", 32'(is_proper_subset), 32'(w.psub));
					if (is_disjoint !== w.dis)
						report("is_disjoint", 32'(is_disjoint), 32'(w.dis));
					if (is_equal !== w.eq) report("is_equal", 32'(is_equal), 32'(w.eq));
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

FILE: bench/tb_two_set_membership_engine.sv
// Testbench top for the two-set membership engine: clock, reset, stimulus
// and verdict. Depends on tsme_pkg, two_set_membership_engine, tsme_checker.
`timescale 1ns / 1ps

module tb_two_set_membership_engine;

	localparam int CAP = 16;
	localparam int CYCLE_LIMIT = 4000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [3:0]         opcode = '0;
	logic               set_select = 1'b0;
	logic signed [31:0] element = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_element;
	logic               has_element;
	logic               last;
	logic               found;
	logic [4:0]         count;
	logic               overflow;
	logic               is_subset;
	logic               is_proper_subset;
	logic               is_disjoint;
	logic               is_equal;
	int                 errors;
	int                 pending;
	int                 cycles = 0;
	bit                 calm = 1'b0;
	logic [31:0]        pool [8];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	two_set_membership_engine #(.SET_CAPACITY(CAP), .ELEMENT_BITS(32)) i_dut (.*);

	tsme_checker #(.CAP(CAP)) i_checker (.*);

	// Stall the result side at random, except in the calm stretch
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 26);

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_set_membership_engine: mismatch");
			$finish;
		end
	end

	// Present one item and hold it until accepted
	task automatic send_item(tsme_pkg::opcode_t op, logic sel, logic [31:0] v);
		if (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (!calm && $urandom_range(99) < 26)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		set_select <= sel;
		element <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_raw(logic [3:0] op, logic sel, logic [31:0] v);
		send_item(tsme_pkg::opcode_t'(op), sel, v);
	endtask

	initial begin
		logic [3:0] op;
		for (int i = 0; i < 8; i++)
			pool[i] = $urandom();
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7fff_ffff;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every operation, full set, unused opcodes
		send_item(tsme_pkg::OP_RELATIONS, 1'b0, '0);
		send_item(tsme_pkg::OP_UNION, 1'b0, '0);
		send_item(tsme_pkg::OP_INSERT, 1'b0, 32'h8000_0000);
		send_item(tsme_pkg::OP_INSERT, 1'b0, 32'h7fff_ffff);
		send_item(tsme_pkg::OP_INSERT, 1'b0, 32'h7fff_ffff);
		send_item(tsme_pkg::OP_INSERT, 1'b1, 32'hffff_ffff);
		send_item(tsme_pkg::OP_INSERT, 1'b1, 32'h7fff_ffff);
		send_item(tsme_pkg::OP_CONTAINS, 1'b0, 32'h8000_0000);
		send_item(tsme_pkg::OP_UNION, 1'b0, '0);
		send_item(tsme_pkg::OP_INTERSECT, 1'b1, '0);
		send_item(tsme_pkg::OP_DIFF, 1'b0, '0);
		send_item(tsme_pkg::OP_SYMDIFF, 1'b1, '0);
		send_item(tsme_pkg::OP_RELATIONS, 1'b1, '0);
		send_item(tsme_pkg::OP_ERASE, 1'b0, 32'h1234);
		send_item(tsme_pkg::OP_ERASE, 1'b0, 32'h8000_0000);
		send_item(tsme_pkg::OP_RELATIONS, 1'b0, '0);
		for (int i = 0; i < CAP + 1; i++)
			send_item(tsme_pkg::OP_INSERT, 1'b1, 32'(i));
		send_item(tsme_pkg::OP_INSERT, 1'b1, 32'd3);
		send_item(tsme_pkg::OP_UNION, 1'b1, '0);
		send_raw(4'd9, 1'b1, '0);
		send_raw(4'd15, 1'b0, '1);
		send_item(tsme_pkg::OP_CLEAR, 1'b1, '0);
		send_item(tsme_pkg::OP_RELATIONS, 1'b1, '0);

		// Hold off until every result is in
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (5) @(posedge clk);

		// Random: mostly values from an eight-entry pool, some full-range
		for (int n = 0; n < 280; n++) begin
			calm = (n >= 100 && n < 140);
			op = ($urandom_range(99) < 45) ? tsme_pkg::OP_INSERT : 4'($urandom_range(15));
			if (op == tsme_pkg::OP_CLEAR && $urandom_range(3) != 0)
				op = tsme_pkg::OP_ERASE;
			send_raw(op, 1'($urandom_range(1)),
				($urandom_range(3) == 0) ? $urandom() : pool[$urandom_range(7)]);
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("two_set_membership_engine: match");
		else
			$display("two_set_membership_engine: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/tsme_pkg.sv
rtl/core/two_set_membership_engine.sv
bench/tsme_checker.sv
bench/tb_two_set_membership_engine.sv
